[rtl/core/fusr_pkg.sv]
package fusr_pkg;

  localparam int ADDR_BITS   = 48;
  localparam int SPAN_W      = 45;  // data_start_sector * bytes_per_sector
  localparam int CB_W        = 21;  // clus_sectors * bytes_per_sector
  localparam int COUNT_W     = 28;
  localparam int PARTIAL_W   = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_ADDR_W  = 6;
  localparam int APB_DATA_W  = 64;
  localparam int REG_IDX_W   = 3;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2,
    KIND_FAT32_ALT = 2'd3
  } fat_kind_t;

  localparam logic [REG_IDX_W-1:0] REG_FAT_KIND      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PART_OFFSET   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DATA_START    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SECT_PER_CLUS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BYTES_PER_SEC = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLUSTER_COUNT = 3'd5;

  typedef struct packed {
    fat_kind_t    fat_kind;
    addr_t        partition_byte_offset;
    logic [31:0]  data_start_sector;
    logic [7:0]   clus_sectors;
    logic [12:0]  bytes_per_sector;
    logic [COUNT_W-1:0] cluster_count;
  } cfg_t;

  // one command from the byte front end to the range back end
  typedef struct packed {
    logic              first;
    addr_t             offset;
    logic [SPAN_W-1:0] span;
    logic              examine;
    logic              used;
    logic              counted;
    logic              finish;
    logic [CB_W-1:0]   cb;
  } cmd_t;

  typedef struct packed {
    addr_t range_start;
    addr_t range_end;
    logic  final_range;
    logic  last_of_item;
  } result_t;

endpackage

[rtl/core/fusr_byte_if.sv]
interface fusr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] fat_byte;

  modport source (output valid, output fat_byte, input ready);
  modport sink (input valid, input fat_byte, output ready);
endinterface

[rtl/core/fusr_range_if.sv]
interface fusr_range_if;
  logic            valid;
  logic            ready;
  fusr_pkg::addr_t range_start;
  fusr_pkg::addr_t range_end;
  logic            final_range;
  logic            last_of_item;

  modport source (output valid, output range_start, output range_end,
                  output final_range, output last_of_item, input ready);
  modport sink (input valid, input range_start, input range_end,
                input final_range, input last_of_item, output ready);
endinterface

[rtl/core/fusr_front.sv]
module fusr_front (
  input  logic               clk,
  input  logic               rst,
  fusr_byte_if.sink          table_bytes,
  input  fusr_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               push,
  output fusr_pkg::cmd_t     cmd
);

  logic [fusr_pkg::COUNT_W-1:0]   entry_number, entry_number_next;
  logic [1:0]                     header_seen, header_seen_next;
  logic [1:0]                     byte_phase, byte_phase_next;
  logic [fusr_pkg::PARTIAL_W-1:0] partial_entry, partial_entry_next;
  logic                           started, started_next;
  logic                           finished, finished_next;

  logic                           accept;
  logic                           done;
  logic [27:0]                    entry;
  logic                           do_examine;
  logic                           counted;
  logic [fusr_pkg::COUNT_W-1:0]   count_after;
  logic [7:0]                     b;

  assign b = table_bytes.fat_byte;
  assign table_bytes.ready = !q_full;
  assign accept = table_bytes.valid && !q_full;

  // entries, little-endian: 12-bit two per 3 bytes, 16-bit of 2, 28-bit of 4
  always_comb begin
    done = 1'b0;
    entry = '0;
    byte_phase_next = byte_phase;
    partial_entry_next = partial_entry;
    unique case (cfg.fat_kind)
      fusr_pkg::KIND_FAT12: begin
        if (byte_phase == 2'd0) begin
          partial_entry_next = {16'd0, b};
          byte_phase_next = 2'd1;
        end else if (byte_phase == 2'd1) begin
          entry = {16'd0, b[3:0], partial_entry[7:0]};
          partial_entry_next = {8'd0, b, partial_entry[7:0]};
          byte_phase_next = 2'd2;
          done = 1'b1;
        end else begin
          entry = {16'd0, b, partial_entry[15:12]};
          partial_entry_next = '0;
          byte_phase_next = 2'd0;
          done = 1'b1;
        end
      end
      fusr_pkg::KIND_FAT16: begin
        if (byte_phase == 2'd0) begin
          partial_entry_next = {16'd0, b};
          byte_phase_next = 2'd1;
        end else begin
          entry = {12'd0, b, partial_entry[7:0]};
          partial_entry_next = '0;
          byte_phase_next = 2'd0;
          done = 1'b1;
        end
      end
      fusr_pkg::KIND_FAT32, fusr_pkg::KIND_FAT32_ALT: begin
        unique case (byte_phase)
          2'd0: partial_entry_next = partial_entry | {16'd0, b};
          2'd1: partial_entry_next = partial_entry | {8'd0, b, 8'd0};
          2'd2: partial_entry_next = partial_entry | {b, 16'd0};
          default: begin
            entry = {b[3:0], partial_entry};
            partial_entry_next = '0;
            done = 1'b1;
          end
        endcase
        byte_phase_next = byte_phase + 2'd1;
      end
      default: ;
    endcase
  end

  assign do_examine = done && (header_seen == 2'd2);
  assign counted = entry_number < cfg.cluster_count;
  assign count_after = counted ? entry_number + 1'b1 : entry_number;

  always_comb begin
    entry_number_next = entry_number;
    header_seen_next = header_seen;
    started_next = started;
    finished_next = finished;
    push = 1'b0;
    if (accept && !finished) begin
      started_next = 1'b1;
      if (done && header_seen != 2'd2) header_seen_next = header_seen + 2'd1;
      if (do_examine) begin
        entry_number_next = count_after;
        if (count_after >= cfg.cluster_count) finished_next = 1'b1;
      end
      push = !started || do_examine;
    end
  end

  always_comb begin
    cmd.first = !started;
    cmd.offset = cfg.partition_byte_offset;
    cmd.span = fusr_pkg::SPAN_W'(cfg.data_start_sector)
             * fusr_pkg::SPAN_W'(cfg.bytes_per_sector);
    cmd.examine = do_examine;
    cmd.used = entry != '0;
    cmd.counted = counted;
    cmd.finish = count_after >= cfg.cluster_count;
    cmd.cb = fusr_pkg::CB_W'(cfg.clus_sectors)
           * fusr_pkg::CB_W'(cfg.bytes_per_sector);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_number <= '0;
      header_seen <= '0;
      byte_phase <= '0;
      partial_entry <= '0;
      started <= 1'b0;
      finished <= 1'b0;
    end else begin
      entry_number <= entry_number_next;
      header_seen <= header_seen_next;
      started <= started_next;
      finished <= finished_next;
      if (accept && !finished) begin
        byte_phase <= byte_phase_next;
        partial_entry <= partial_entry_next;
      end
    end
  end

endmodule

[rtl/core/fusr_queue.sv]
module fusr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fusr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output fusr_pkg::cmd_t pop_cmd
);

  fusr_pkg::cmd_t                 mem [fusr_pkg::QUEUE_DEPTH];
  logic [fusr_pkg::QPTR_W-1:0]    wr_ptr;
  logic [fusr_pkg::QPTR_W-1:0]    rd_ptr;
  logic [fusr_pkg::QCNT_W-1:0]    count;

  assign full = count == fusr_pkg::QCNT_W'(fusr_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[rtl/core/fusr_back.sv]
module fusr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  fusr_pkg::cmd_t q_cmd,
  output logic           pop,
  fusr_range_if.source   ranges
);

  fusr_pkg::addr_t  cba, cba_next;
  logic             run_open, run_open_next;
  fusr_pkg::addr_t  run_first, run_first_next;
  fusr_pkg::addr_t  run_last, run_last_next;
  logic             out_valid;
  fusr_pkg::result_t out_res;
  logic             pend_valid;
  fusr_pkg::result_t pend_res;

  fusr_pkg::result_t r0, r1;
  logic             has0, has1;
  logic             can_load;
  logic             adj;
  logic             brk;
  logic             fin;
  fusr_pkg::addr_t  cb;
  fusr_pkg::addr_t  span;

  assign cb = fusr_pkg::ADDR_BITS'(q_cmd.cb);
  assign span = fusr_pkg::ADDR_BITS'(q_cmd.span);
  assign can_load = !out_valid || ranges.ready;
  assign pop = !pend_valid && q_valid && can_load;
  assign adj = run_open && (run_last + 1'b1 == cba);

  always_comb begin
    cba_next = cba;
    run_open_next = run_open;
    run_first_next = run_first;
    run_last_next = run_last;
    brk = 1'b0;
    fin = 1'b0;
    has0 = 1'b0;
    has1 = 1'b0;
    r0 = '0;
    r1 = '0;
    if (q_cmd.first) begin
      // reserved and metadata area ahead of cluster 2
      cba_next = q_cmd.offset + span;
      has0 = span != '0;
      r0 = '{range_start: q_cmd.offset, range_end: q_cmd.offset + span - 1'b1,
             final_range: 1'b0, last_of_item: 1'b1};
    end else if (q_cmd.examine) begin
      if (q_cmd.counted) begin
        if (q_cmd.used) begin
          if (adj) begin
            run_last_next = run_last + cb;
          end else begin
            brk = run_open;
            run_first_next = cba;
            run_last_next = cba + cb - 1'b1;
            run_open_next = 1'b1;
          end
        end
        cba_next = cba + cb;
      end
      fin = q_cmd.finish && run_open_next;
      if (fin) run_open_next = 1'b0;
      if (brk) begin
        has0 = 1'b1;
        r0 = '{range_start: run_first, range_end: run_last,
               final_range: 1'b0, last_of_item: !fin};
        has1 = fin;
        r1 = '{range_start: run_first_next, range_end: run_last_next,
               final_range: 1'b1, last_of_item: 1'b1};
      end else begin
        has0 = fin;
        r0 = '{range_start: run_first_next, range_end: run_last_next,
               final_range: 1'b1, last_of_item: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cba <= '0;
      run_open <= 1'b0;
      run_first <= '0;
      run_last <= '0;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid) begin
        if (can_load) begin
          out_valid <= 1'b1;
          out_res <= pend_res;
          pend_valid <= 1'b0;
        end
      end else if (pop) begin
        cba <= cba_next;
        run_open <= run_open_next;
        run_first <= run_first_next;
        run_last <= run_last_next;
        out_valid <= has0;
        out_res <= r0;
        pend_valid <= has1;
        pend_res <= r1;
      end else if (can_load) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ranges.valid = out_valid;
  assign ranges.range_start = out_res.range_start;
  assign ranges.range_end = out_res.range_end;
  assign ranges.final_range = out_res.final_range;
  assign ranges.last_of_item = out_res.last_of_item;

endmodule

[rtl/core/fat_used_cluster_run_scanner_top.sv]
// channel      dir   beat payload                                      handshake
// table_bytes  in    fat_byte[7:0]                                     valid/ready
// ranges       out   range_start[47:0] range_end[47:0] final_range     valid/ready
//                    last_of_item
// apb          in    6 registers at 8*i, 64-bit data                   psel/penable
//
// one table byte per cycle while the queue has room; a byte that breaks a run
// and also ends the scan gives two beats, the second held in a pending register
// a 4-deep command queue sits between byte assembly and range tracking
// rst is synchronous; registers return to their reset values, scan restarts
// a stalled output only backs up the queue; bytes keep flowing until it fills
module fat_used_cluster_run_scanner_top (
  input  logic                              clk,
  input  logic                              rst,
  fusr_byte_if.sink                         table_bytes,
  fusr_range_if.source                      ranges,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fusr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fusr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fusr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  fusr_pkg::cfg_t              cfg;
  logic [fusr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                        wr_en;
  logic                        push;
  fusr_pkg::cmd_t              push_cmd;
  logic                        q_full;
  logic                        q_valid;
  logic                        pop;
  fusr_pkg::cmd_t              q_cmd;

  assign pready = 1'b1;
  assign reg_idx = paddr[fusr_pkg::APB_ADDR_W-1:3];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat_kind <= fusr_pkg::KIND_FAT16;
      cfg.partition_byte_offset <= '0;
      cfg.data_start_sector <= '0;
      cfg.clus_sectors <= 8'd1;
      cfg.bytes_per_sector <= 13'd512;
      cfg.cluster_count <= 28'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        fusr_pkg::REG_FAT_KIND:      cfg.fat_kind <= fusr_pkg::fat_kind_t'(pwdata[1:0]);
        fusr_pkg::REG_PART_OFFSET:
          cfg.partition_byte_offset <= pwdata[fusr_pkg::ADDR_BITS-1:0];
        fusr_pkg::REG_DATA_START:    cfg.data_start_sector <= pwdata[31:0];
        fusr_pkg::REG_SECT_PER_CLUS: cfg.clus_sectors <= pwdata[7:0];
        fusr_pkg::REG_BYTES_PER_SEC: cfg.bytes_per_sector <= pwdata[12:0];
        fusr_pkg::REG_CLUSTER_COUNT: cfg.cluster_count <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fusr_pkg::REG_FAT_KIND:      prdata = 64'(cfg.fat_kind);
      fusr_pkg::REG_PART_OFFSET:   prdata = 64'(cfg.partition_byte_offset);
      fusr_pkg::REG_DATA_START:    prdata = 64'(cfg.data_start_sector);
      fusr_pkg::REG_SECT_PER_CLUS: prdata = 64'(cfg.clus_sectors);
      fusr_pkg::REG_BYTES_PER_SEC: prdata = 64'(cfg.bytes_per_sector);
      fusr_pkg::REG_CLUSTER_COUNT: prdata = 64'(cfg.cluster_count);
      default:                     prdata = '0;
    endcase
  end

  fusr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .table_bytes (table_bytes),
    .cfg         (cfg),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  fusr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_cmd   (q_cmd)
  );

  fusr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .ranges  (ranges)
  );

endmodule

[rtl/core/fusr_checker.sv]
module fusr_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input fusr_pkg::addr_t       range_start,
  input fusr_pkg::addr_t       range_end,
  input logic                  final_range,
  input logic                  last_of_item
);

  // a held beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(range_start)
      && $stable(range_end) && $stable(final_range) && $stable(last_of_item))
    else $error("range beat changed while stalled");

  // the closing range is always the last beat of its byte
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_range |-> last_of_item)
    else $error("final range not marked last");

  // nothing is queued behind the closing range
  a_final_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && final_range |=> !out_valid)
    else $error("beat after final range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind fat_used_cluster_run_scanner_top fusr_checker u_fusr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (ranges.valid),
  .out_ready    (ranges.ready),
  .range_start  (ranges.range_start),
  .range_end    (ranges.range_end),
  .final_range  (ranges.final_range),
  .last_of_item (ranges.last_of_item)
);
